// ===== design/sseg_pkg.sv =====
// Shared types, constants and the digit segment table of the seven-segment glyph rasterizer.
package sseg_pkg;

  // Field types of one input word and one result word
  typedef logic [7:0] char_code_t;
  typedef logic [6:0] column_t;
  typedef logic [2:0] page_t;
  typedef logic [7:0] pixel_byte_t;

  // Configuration register types
  typedef logic [6:0] height_t;
  typedef logic [7:0] width_t;
  typedef logic [4:0] stroke_t;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STROKE = 2'd2;

  // Register reset values
  localparam height_t HEIGHT_RST = 7'd32;
  localparam width_t  WIDTH_RST  = 8'd16;
  localparam stroke_t STROKE_RST = 5'd3;

  // Display memory limits
  localparam logic [8:0] MAX_WIDTH = 9'd128;
  localparam logic [4:0] MAX_PAGES = 5'd8;
  localparam int         PAGE_ROWS = 8;

  // Recognized character codes
  localparam char_code_t CH_ZERO  = 8'h30;
  localparam char_code_t CH_NINE  = 8'h39;
  localparam char_code_t CH_COLON = 8'h3A;
  localparam char_code_t CH_SPACE = 8'h20;

  // Segment bit positions
  localparam int SEG_LB  = 0;
  localparam int SEG_LT  = 1;
  localparam int SEG_RT  = 2;
  localparam int SEG_RB  = 3;
  localparam int SEG_BOT = 4;
  localparam int SEG_MID = 5;
  localparam int SEG_TOP = 6;

  typedef logic [6:0] segs_t;

  // Geometry derived from the configuration registers
  typedef struct packed {
    height_t    height;
    width_t     width;
    stroke_t    stroke;
    logic [7:0] vlen;     // vertical bar length
    logic [7:0] xr;       // right bar start column
    logic [7:0] yb;       // lower vertical bars start row
    logic [7:0] hw;       // horizontal bar width
    logic [7:0] ybot;     // bottom bar start row
    logic [7:0] ymid;     // middle bar start row
    logic [7:0] c0;       // colon first column
    logic [7:0] c1;       // colon column bound (exclusive)
    logic [7:0] y1;       // upper dot start row
    logic [7:0] y2;       // lower dot start row
    logic [4:0] dh;       // dot height
  } geom_t;

  function automatic segs_t digit_segs(input logic [3:0] d);
    segs_t s;
    case (d)
      4'd0:    s = 7'h5F;
      4'd1:    s = 7'h0C;
      4'd2:    s = 7'h75;
      4'd3:    s = 7'h7C;
      4'd4:    s = 7'h2E;
      4'd5:    s = 7'h7A;
      4'd6:    s = 7'h7B;
      4'd7:    s = 7'h4C;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h7E;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== design/sseg_in_if.sv =====
// Input channel: one character/column/page word per handshake.
interface sseg_in_if import sseg_pkg::*;;
  logic       valid;
  logic       ready;
  char_code_t char_code;
  column_t    column;
  page_t      page;

  modport source (output valid, char_code, column, page, input ready);
  modport sink   (input valid, char_code, column, page, output ready);
endinterface

// ===== design/sseg_out_if.sv =====
// Result channel: one display memory byte and its write enable per handshake.
interface sseg_out_if import sseg_pkg::*;;
  logic        valid;
  logic        ready;
  pixel_byte_t pixel_byte;
  logic        write_enable;

  modport source (output valid, pixel_byte, write_enable, input ready);
  modport sink   (input valid, pixel_byte, write_enable, output ready);
endinterface

// ===== design/sseg_geom.sv =====
// Glyph geometry derived from height, width and stroke registers.
module sseg_geom import sseg_pkg::*; (
  input  height_t height,
  input  width_t  width,
  input  stroke_t stroke,
  output geom_t   geom
);

  logic [6:0]        t3;
  logic signed [8:0] vdiff;
  logic signed [8:0] vhalf;
  logic signed [8:0] mdiff;
  logic signed [8:0] mhalf;
  logic [7:0]        hsum;
  logic [15:0]       wprod;
  logic [13:0]       hprod;
  logic [6:0]        dw;
  logic [4:0]        dh;
  logic [8:0]        csum;
  logic [8:0]        h3;

  assign t3    = {1'b0, stroke, 1'b0} + {2'b00, stroke};
  // truncate toward zero on the signed halves
  assign vdiff = $signed({2'b00, height}) - $signed({2'b00, t3});
  assign vhalf = (vdiff + {8'd0, vdiff[8]}) >>> 1;
  assign mdiff = $signed({2'b00, height}) - $signed({4'd0, stroke});
  assign mhalf = (mdiff + {8'd0, mdiff[8]}) >>> 1;
  assign hsum  = {1'b0, height} + {3'd0, stroke};

  // divide by 3 through reciprocal 171/512, exact for 8-bit operands
  assign wprod = width * 8'd171;
  assign dw    = wprod[15:9];
  assign hprod = height[6:1] * 8'd171;
  assign dh    = hprod[13:9];
  assign csum  = {1'b0, width} + {2'b00, dw};
  assign h3    = {1'b0, height, 1'b0} + {2'b00, height};

  always_comb begin
    geom.height = height;
    geom.width  = width;
    geom.stroke = stroke;
    geom.vlen   = vhalf[7:0];
    geom.xr     = width - {3'd0, stroke};
    geom.yb     = {1'b0, hsum[7:1]};
    geom.hw     = width - {2'd0, stroke, 1'b0};
    geom.ybot   = mdiff[7:0];
    geom.ymid   = mhalf[7:0];
    geom.c0     = (width - {1'b0, dw}) >> 1;
    geom.c1     = csum[8:1];
    geom.y1     = {3'd0, height[6:2]} - {4'd0, dh[4:1]};
    geom.y2     = {1'b0, h3[8:2]} - {4'd0, dh[4:1]};
    geom.dh     = dh;
  end

endmodule

// ===== design/sseg_raster.sv =====
// Byte of the glyph at one column and page, with its write enable.
module sseg_raster import sseg_pkg::*; (
  input  geom_t       geom,
  input  char_code_t  char_code,
  input  column_t     column,
  input  page_t       page,
  output pixel_byte_t pixel_byte,
  output logic        write_enable
);

  function automatic logic [7:0] rows_mask(input page_t pg, input logic [7:0] y0,
                                           input logic [7:0] len);
    logic [7:0] m;
    logic [7:0] r;
    m = 8'd0;
    for (int b = 0; b < PAGE_ROWS; b++) begin
      r = {2'b00, pg, 3'(b)};
      m[b] = (r >= y0) && ((r - y0) < len);
    end
    return m;
  endfunction

  function automatic logic col_in(input column_t c, input logic [7:0] x0,
                                  input logic [7:0] len);
    return ({1'b0, c} >= x0) && (({1'b0, c} - x0) < len);
  endfunction

  logic       is_digit;
  logic       known;
  logic       in_glyph;
  segs_t      segs;
  logic [7:0] tt;
  logic       in_left;
  logic       in_right;
  logic       in_hbar;
  logic [7:0] mask_top_v;
  logic [7:0] mask_bot_v;
  logic [7:0] digit_px;
  logic [7:0] colon_px;
  logic [7:0] px;
  logic [7:0] char_off;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign known    = is_digit || (char_code == CH_SPACE) || (char_code == CH_COLON);
  assign in_glyph = ({1'b0, column} < geom.width) && ({2'b00, column} < MAX_WIDTH) &&
                    ({3'b000, page, 3'b000} < {2'b00, geom.height}) &&
                    ({2'b00, page} < MAX_PAGES);

  assign char_off = char_code - CH_ZERO;
  assign segs     = is_digit ? digit_segs(char_off[3:0]) : '0;
  assign tt       = {3'd0, geom.stroke};

  assign in_left    = col_in(column, 8'd0, tt);
  assign in_right   = col_in(column, geom.xr, tt);
  assign in_hbar    = col_in(column, tt, geom.hw);
  assign mask_top_v = rows_mask(page, tt, geom.vlen);
  assign mask_bot_v = rows_mask(page, geom.yb, geom.vlen);

  always_comb begin
    digit_px = 8'd0;
    if (segs[SEG_LB] && in_left)  digit_px = digit_px | mask_bot_v;
    if (segs[SEG_LT] && in_left)  digit_px = digit_px | mask_top_v;
    if (segs[SEG_RT] && in_right) digit_px = digit_px | mask_top_v;
    if (segs[SEG_RB] && in_right) digit_px = digit_px | mask_bot_v;
    if (in_hbar) begin
      if (segs[SEG_BOT]) digit_px = digit_px | rows_mask(page, geom.ybot, tt);
      if (segs[SEG_MID]) digit_px = digit_px | rows_mask(page, geom.ymid, tt);
      if (segs[SEG_TOP]) digit_px = digit_px | rows_mask(page, 8'd0, tt);
    end
  end

  always_comb begin
    colon_px = 8'd0;
    if (({1'b0, column} >= geom.c0) && ({1'b0, column} < geom.c1)) begin
      colon_px = rows_mask(page, geom.y1, {3'd0, geom.dh}) |
                 rows_mask(page, geom.y2, {3'd0, geom.dh});
    end
  end

  always_comb begin
    if (char_code == CH_COLON) begin
      px = colon_px;
    end else if (is_digit) begin
      px = digit_px;
    end else begin
      px = 8'd0;
    end
  end

  assign write_enable = known && in_glyph;
  assign pixel_byte   = write_enable ? px : 8'd0;

endmodule

// ===== design/seven_segment_glyph_rasterizer.sv =====
// Top level of the seven-segment glyph rasterizer.
//
// Usage:
//   in_ch  : one word per handshake (valid && ready) carrying char_code,
//            column and page. Digits, space and colon are recognized.
//   out_ch : one word per accepted input: pixel_byte (bit 0 = top row of the
//            page) and write_enable. An unknown character or an address
//            outside the glyph gives write_enable 0 and a zero byte.
//   cfg_*  : write port for glyph_height (index 0), glyph_width (index 1) and
//            stroke_thickness (index 2), taken on any edge with cfg_we high.
//            Write only while no word is in flight.
// Timing: an accepted word passes through the input register, then the result
//   register, before out_ch.valid rises; one word is accepted every cycle while
//   out_ch.ready does not stall the pipeline. The path between the two registers
//   is the geometry arithmetic (a divide-by-3 reciprocal multiply) followed by
//   the row and column compares.
// Reset: rst_n low at a clock edge empties both registers and restores
//   height 32, width 16, stroke 3.
// Stall: when out_ch.ready is low the result register holds its word; the
//   input register still fills while the result register is full, and
//   in_ch.ready drops only once both are occupied.
module seven_segment_glyph_rasterizer import sseg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  sseg_in_if.sink                in_ch,
  sseg_out_if.source             out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  height_t height_r;
  width_t  width_r;
  stroke_t stroke_r;

  // Input register
  logic       item_valid_r;
  char_code_t item_char_r;
  column_t    item_col_r;
  page_t      item_page_r;

  // Result register
  logic        out_valid_r;
  pixel_byte_t out_byte_r;
  logic        out_we_r;

  geom_t       geom;
  pixel_byte_t rast_byte;
  logic        rast_we;
  logic        out_adv;
  logic        in_adv;

  // Advance the result register when empty or taken; the input register
  // follows whenever its word moves on.
  assign out_adv = !out_valid_r || out_ch.ready;
  assign in_adv  = !item_valid_r || out_adv;

  assign in_ch.ready         = in_adv;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_byte   = out_byte_r;
  assign out_ch.write_enable = out_we_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RST;
      width_r  <= WIDTH_RST;
      stroke_r <= STROKE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEIGHT: height_r <= cfg_data[6:0];
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_STROKE: stroke_r <= cfg_data[4:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_adv) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_ch.valid) begin
      item_char_r <= in_ch.char_code;
      item_col_r  <= in_ch.column;
      item_page_r <= in_ch.page;
    end
  end

  // Geometry follows the configuration registers directly so that a word
  // accepted right after a write sees the new values.
  sseg_geom u_geom (
    .height (height_r),
    .width  (width_r),
    .stroke (stroke_r),
    .geom   (geom)
  );

  sseg_raster u_raster (
    .geom         (geom),
    .char_code    (item_char_r),
    .column       (item_col_r),
    .page         (item_page_r),
    .pixel_byte   (rast_byte),
    .write_enable (rast_we)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= item_valid_r;
    end
  end

  // Hold the result while the receiver stalls.
  always_ff @(posedge clk) begin
    if (out_adv && item_valid_r) begin
      out_byte_r <= rast_byte;
      out_we_r   <= rast_we;
    end
  end

endmodule

// ===== design/sseg_checker.sv =====
// Port-level checks for the seven-segment glyph rasterizer, bound to the top level.
module sseg_checker import sseg_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input pixel_byte_t out_pixel_byte,
  input logic        out_write_enable
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_byte) && $stable(out_write_enable))
    else $error("result payload changed while stalled");

  // Once a word is accepted, out_valid follows after the input and result registers.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing two cycles after acceptance");

  // A suppressed write carries a zero byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_pixel_byte == 8'd0)
    else $error("nonzero byte with write_enable low");

  // Reset empties the output.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind seven_segment_glyph_rasterizer sseg_checker u_sseg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_pixel_byte   (out_ch.pixel_byte),
  .out_write_enable (out_ch.write_enable)
);
